FILE: rtl/plid_pkg.sv
// ----------------------------------------------------------------------------
// plid_pkg
// Shared types and constants for the positional insert/delete list.
// ----------------------------------------------------------------------------
package plid_pkg;

   localparam int CAPACITY   = 16;
   localparam int DATA_WIDTH = 32;

   // fixed field widths of the transaction payloads
   localparam int OPCODE_W = 3;
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 5;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   // internal widths
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

   typedef logic [DATA_WIDTH-1:0] data_type;
   typedef logic [CNT_W-1:0]      cnt_type;
   typedef logic [IDX_W-1:0]      idx_type;

   typedef enum logic [OPCODE_W-1:0] {
      OP_INS_FRONT = 3'd0,
      OP_INS_BACK  = 3'd1,
      OP_INS_POS   = 3'd2,
      OP_DEL_FRONT = 3'd3,
      OP_DEL_BACK  = 3'd4,
      OP_DEL_POS   = 3'd5
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK     = 2'd0,
      ST_BADPOS = 2'd1,
      ST_FULL   = 2'd2,
      ST_EMPTY  = 2'd3
   } status_type;

   // broadcast to every cell; ins/del are already qualified by the handshake
   typedef struct packed {
      logic    ins;
      logic    del;
      idx_type idx;
   } cell_cmd_type;

endpackage

FILE: rtl/plid_if.sv
// ----------------------------------------------------------------------------
// plid_req_if / plid_rsp_if
// Valid/ready channels for requests and responses.
// ----------------------------------------------------------------------------
interface plid_req_if
   import plid_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic signed [VALUE_W-1:0] item_value;
   logic [POS_W-1:0]    position;

   modport source (output valid, opcode, item_value, position, input ready);
   modport sink   (input valid, opcode, item_value, position, output ready);
endinterface

interface plid_rsp_if
   import plid_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [COUNT_W-1:0]  entry_count;

   modport source (output valid, status, entry_count, input ready);
   modport sink   (input valid, status, entry_count, output ready);
endinterface

FILE: rtl/plid_cell.sv
// ----------------------------------------------------------------------------
// plid_cell
// One list slot; loads new data or takes a neighbor's value on a shift.
// ----------------------------------------------------------------------------
module plid_cell
   import plid_pkg::*;
(
   input  logic         clock,
   input  idx_type      slot_index,
   input  cell_cmd_type cmd,
   input  data_type     new_value,
   input  data_type     prev_value,
   input  data_type     next_value,
   output data_type     value
);

   data_type value_ff;
   data_type value_in;

   always_comb begin
      value_in = value_ff;
      if (cmd.ins) begin
         if (slot_index == cmd.idx) begin
            value_in = new_value;
         end else if (slot_index > cmd.idx) begin
            value_in = prev_value;
         end
      end else if (cmd.del && (slot_index >= cmd.idx)) begin
         value_in = next_value;
      end
   end

   // payload only, no reset
   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

FILE: rtl/plid_ctrl.sv
// ----------------------------------------------------------------------------
// plid_ctrl
// Request decode, range checks and the entry count.
// ----------------------------------------------------------------------------
module plid_ctrl
   import plid_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  logic [OPCODE_W-1:0] opcode,
   input  logic [POS_W-1:0]    position,
   output cell_cmd_type        cmd,
   output status_type          status,
   output cnt_type             count_next
);

   cnt_type      count_ff;
   cnt_type      count_in;
   logic         full;
   logic         empty;
   logic [CMP_W-1:0] pos_w;
   logic [CMP_W-1:0] cnt_w;
   logic         do_ins;
   logic         do_del;
   idx_type      idx;

   assign full  = (count_ff == cnt_type'(CAPACITY));
   assign empty = (count_ff == '0);
   assign pos_w = CMP_W'(position);
   assign cnt_w = CMP_W'(count_ff);

   always_comb begin
      status = ST_OK;
      do_ins = 1'b0;
      do_del = 1'b0;
      idx    = '0;
      case (opcode_type'(opcode))
         OP_INS_FRONT: begin
            if (full) status = ST_FULL;
            else      do_ins = 1'b1;
         end
         OP_INS_BACK: begin
            if (full) status = ST_FULL;
            else begin
               do_ins = 1'b1;
               idx    = idx_type'(count_ff);
            end
         end
         OP_INS_POS: begin
            if ((pos_w == '0) || (pos_w > cnt_w + CMP_W'(1))) status = ST_BADPOS;
            else if (full) status = ST_FULL;
            else begin
               do_ins = 1'b1;
               idx    = idx_type'(pos_w - CMP_W'(1));
            end
         end
         OP_DEL_FRONT: begin
            if (empty) status = ST_EMPTY;
            else       do_del = 1'b1;
         end
         OP_DEL_BACK: begin
            if (empty) status = ST_EMPTY;
            else begin
               do_del = 1'b1;
               idx    = idx_type'(count_ff - cnt_type'(1));
            end
         end
         OP_DEL_POS: begin
            if (empty) status = ST_EMPTY;
            else if ((pos_w == '0) || (pos_w > cnt_w)) status = ST_BADPOS;
            else begin
               do_del = 1'b1;
               idx    = idx_type'(pos_w - CMP_W'(1));
            end
         end
         default: status = ST_BADPOS;
      endcase
   end

   always_comb begin
      count_next = count_ff;
      if (do_ins)      count_next = count_ff + cnt_type'(1);
      else if (do_del) count_next = count_ff - cnt_type'(1);
   end

   assign count_in = fire ? count_next : count_ff;

   assign cmd.ins = fire & do_ins;
   assign cmd.del = fire & do_del;
   assign cmd.idx = idx;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

FILE: rtl/positional_list_insert_delete.sv
// ----------------------------------------------------------------------------
// positional_list_insert_delete
// Bounded ordered list of signed values held in a chain of shifting cells.
//
//   channel | dir | payload                          | handshake
//   --------+-----+----------------------------------+-------------
//   req     | in  | opcode, item_value, position     | valid/ready
//   rsp     | out | status, entry_count              | valid/ready
//
// Every cell shifts or loads at the accepting edge and the response is
// registered at that same edge. Sustained rate is one transaction per
// cycle while rsp.ready is high, set by the cell shift and the one-deep
// response register. Synchronous reset empties the list (count 0) and
// drops rsp.valid; cell contents are not cleared and are never visible
// at the ports. A stalled response holds req.ready low until it is
// taken, unless it is taken in the same cycle.
// ----------------------------------------------------------------------------
module positional_list_insert_delete
   import plid_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   plid_req_if.sink   req,
   plid_rsp_if.source rsp
);

   logic         fire;
   cell_cmd_type cmd;
   status_type   status;
   cnt_type      count_next;
   data_type     new_value;
   data_type     cell_value [CAPACITY];

   // response register
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;

   // accept whenever the output slot is free or draining this cycle
   assign req.ready = ~rsp_valid_ff | rsp.ready;
   assign fire      = req.valid & req.ready;

   // value is kept in the low DATA_WIDTH bits, zero-extended if wider
   assign new_value = DATA_WIDTH'($unsigned(req.item_value));

   plid_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .opcode     (req.opcode),
      .position   (req.position),
      .cmd        (cmd),
      .status     (status),
      .count_next (count_next)
   );

   // Chain of cells. Insert: cells after the slot take from the previous
   // neighbor. Delete: cells from the slot on take from the next one.
   // Ends of the chain get dummy neighbors that are never selected usefully.
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      data_type prev_v;
      data_type next_v;

      if (g == 0) begin : g_first
         assign prev_v = new_value;
      end else begin : g_mid_p
         assign prev_v = cell_value[g-1];
      end

      if (g == CAPACITY - 1) begin : g_last
         assign next_v = cell_value[g];
      end else begin : g_mid_n
         assign next_v = cell_value[g+1];
      end

      plid_cell u_cell (
         .clock      (clock),
         .slot_index (idx_type'(g)),
         .cmd        (cmd),
         .new_value  (new_value),
         .prev_value (prev_v),
         .next_value (next_v),
         .value      (cell_value[g])
      );
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire)           rsp_valid_in = 1'b1;
      else if (rsp.ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, loaded only at acceptance
   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_status_ff <= status;
         rsp_count_ff  <= COUNT_W'(count_next);
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.status      = rsp_status_ff;
   assign rsp.entry_count = rsp_count_ff;

endmodule

FILE: rtl/plid_checker.sv
// ----------------------------------------------------------------------------
// plid_checker
// Port-level checks on the list, bound to the top level.
// ----------------------------------------------------------------------------
module plid_checker
   import plid_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [COUNT_W-1:0]  rsp_entry_count
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
                                  && $stable(rsp_entry_count))
      else $error("response changed while stalled");

   // every accepted request yields a response next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("no response after accepted request");

   // full status only with a full list
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_FULL) |-> rsp_entry_count == COUNT_W'(CAPACITY))
      else $error("full status with non-full count");

   // empty status only with an empty list
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_EMPTY) |-> rsp_entry_count == '0)
      else $error("empty status with non-zero count");

endmodule

bind positional_list_insert_delete plid_checker u_plid_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req.valid),
   .req_ready       (req.ready),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_status      (rsp.status),
   .rsp_entry_count (rsp.entry_count)
);
